/* design/ssmc_pkg.sv */
// shared types, constants and helpers for the subarray sum match counter
// no dependencies; every other design file refers to it by scoped names
package ssmc_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;

   // multiplicative hash constant for the home slot
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // epoch tag kept with every table entry; tag zero never marks a live entry
   localparam int                 EPOCH_W     = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FREE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [31:0]        key;
      logic [31:0]        count;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } table_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_INSERT,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? COUNT_MAX : s[31:0];
   endfunction

endpackage

/* design/ssmc_hash.sv */
// home slot unit: multiplicative hash, fold, then reduction to the table size
// depends on ssmc_pkg; power-of-two sizes take a mask, others a byte-serial remainder
module ssmc_hash #(
   parameter int TABLE_ENTRIES = ssmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [31:0]                      key,
   output logic                             done,
   output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
   localparam int RED_W   = IDX_W + 8;

   logic [31:0]      prod_ff;
   logic             mul_vld_ff;
   logic [31:0]      mix;
   logic             done_ff;
   logic [IDX_W-1:0] slot_ff;

   assign mix  = prod_ff ^ (prod_ff >> 16);
   assign done = done_ff;
   assign slot = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= key * ssmc_pkg::HASH_MULT;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= mul_vld_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (mul_vld_ff) begin
               slot_ff <= mix[IDX_W-1:0];
            end
         end
      end else begin : g_reduce
         localparam logic [RED_W-1:0] N_RED = RED_W'(TABLE_ENTRIES);

         logic [31:0]      mix_ff;
         logic [IDX_W-1:0] rem_ff;
         logic [1:0]       step_ff;
         logic             busy_ff;
         logic [IDX_W-1:0] rem_in;
         logic [RED_W-1:0] t;

         // one byte per cycle, most significant first: rem = (rem * 256 + byte) mod N
         always_comb begin
            t = {rem_ff, mix_ff[31:24]};
            for (int k = 7; k >= 0; k--) begin
               if (t >= (N_RED << k)) begin
                  t = t - (N_RED << k);
               end
            end
            rem_in = t[IDX_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               step_ff <= '0;
               done_ff <= 1'b0;
            end else begin
               done_ff <= 1'b0;
               if (mul_vld_ff) begin
                  busy_ff <= 1'b1;
                  step_ff <= '0;
               end else if (busy_ff) begin
                  step_ff <= step_ff + 2'd1;
                  if (step_ff == 2'd3) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (mul_vld_ff) begin
               mix_ff <= mix;
               rem_ff <= '0;
            end else if (busy_ff) begin
               mix_ff <= mix_ff << 8;
               rem_ff <= rem_in;
               slot_ff <= rem_in;
            end
         end
      end
   endgenerate

endmodule

/* design/ssmc_table.sv */
// prefix sum table: one synchronous memory of epoch, key and count per slot
// depends on ssmc_pkg; one access per cycle, read data registered
module ssmc_table #(
   parameter int TABLE_ENTRIES = ssmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  ssmc_pkg::table_ctl_type          ctl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
   input  ssmc_pkg::entry_type              wr_data,
   output ssmc_pkg::entry_type              rd_data
);

   ssmc_pkg::entry_type mem [TABLE_ENTRIES];
   ssmc_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

/* design/ssmc_seq.sv */
// sequencer: prefix sum, lookup and insert probes over the table, result register
// depends on ssmc_pkg; drives ssmc_hash and ssmc_table
module ssmc_seq #(
   parameter int TABLE_ENTRIES = ssmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [31:0]                      target_sum,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             hash_start,
   output logic [31:0]                      hash_key,
   input  logic                             hash_done,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] hash_slot,
   output ssmc_pkg::table_ctl_type          tbl_ctl,
   output logic [$clog2(TABLE_ENTRIES)-1:0] tbl_addr,
   output ssmc_pkg::entry_type              tbl_wr_data,
   input  ssmc_pkg::entry_type              tbl_rd_data
);

   localparam int               IDX_W    = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   ssmc_pkg::state_type state_ff, state_in;

   logic [31:0]                  sum_ff, sum_in;
   logic [31:0]                  match_ff, match_in;
   logic [31:0]                  zero_cnt_ff, zero_cnt_in;
   logic                         ovf_ff, ovf_in;
   logic                         eos_ff, eos_in;
   logic                         insert_ff, insert_in;
   logic [31:0]                  key_ff, key_in;
   logic                         go_ff, go_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             probes_ff, probes_in;
   logic [ssmc_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   logic [31:0]                  rsp_total_ff;
   logic                         rsp_ovf_ff;
   logic                         rsp_last_ff;

   logic [31:0]      want;
   logic             live;
   logic             hit;
   logic             exhausted;
   logic [IDX_W-1:0] idx_next;

   assign want      = sum_ff - target_sum;
   assign live      = (tbl_rd_data.epoch == epoch_ff);
   assign hit       = live && (tbl_rd_data.key == key_ff);
   assign exhausted = (probes_ff == IDX_LAST);
   assign idx_next  = (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);

   assign req_tready = (state_ff == ssmc_pkg::ST_IDLE);
   assign hash_start = go_ff;
   assign hash_key   = key_ff;
   assign tbl_addr   = idx_ff;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_total_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;
   assign rsp_tlast    = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssmc_pkg::ST_CLEAR;
         sum_ff       <= '0;
         match_ff     <= '0;
         zero_cnt_ff  <= 32'd1;
         ovf_ff       <= 1'b0;
         eos_ff       <= 1'b0;
         insert_ff    <= 1'b0;
         key_ff       <= '0;
         go_ff        <= 1'b0;
         idx_ff       <= '0;
         probes_ff    <= '0;
         epoch_ff     <= ssmc_pkg::EPOCH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         match_ff     <= match_in;
         zero_cnt_ff  <= zero_cnt_in;
         ovf_ff       <= ovf_in;
         eos_ff       <= eos_in;
         insert_ff    <= insert_in;
         key_ff       <= key_in;
         go_ff        <= go_in;
         idx_ff       <= idx_in;
         probes_ff    <= probes_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_total_ff <= match_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= eos_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      match_in     = match_ff;
      zero_cnt_in  = zero_cnt_ff;
      ovf_in       = ovf_ff;
      eos_in       = eos_ff;
      insert_in    = insert_ff;
      key_in       = key_ff;
      go_in        = 1'b0;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      epoch_in     = epoch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_load     = 1'b0;
      tbl_ctl      = '0;
      tbl_wr_data  = '{epoch: epoch_ff, key: key_ff, count: 32'd1};

      case (state_ff)
         ssmc_pkg::ST_CLEAR: begin
            tbl_ctl.wr_en = 1'b1;
            tbl_wr_data   = '{epoch: ssmc_pkg::EPOCH_FREE, key: '0, count: '0};
            idx_in        = idx_next;
            if (idx_ff == IDX_LAST) begin
               state_in = ssmc_pkg::ST_IDLE;
            end
         end
         ssmc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               sum_in   = sum_ff + req_tdata;
               eos_in   = req_tlast;
               state_in = ssmc_pkg::ST_LOOKUP;
            end
         end
         ssmc_pkg::ST_LOOKUP: begin
            // key zero lives in its own counter
            if (want == '0) begin
               match_in = ssmc_pkg::sat_add(match_ff, zero_cnt_ff);
               state_in = ssmc_pkg::ST_INSERT;
            end else begin
               key_in    = want;
               insert_in = 1'b0;
               go_in     = 1'b1;
               state_in  = ssmc_pkg::ST_HASH;
            end
         end
         ssmc_pkg::ST_INSERT: begin
            if (sum_ff == '0) begin
               zero_cnt_in = ssmc_pkg::sat_add(zero_cnt_ff, 32'd1);
               state_in    = ssmc_pkg::ST_DONE;
            end else begin
               key_in    = sum_ff;
               insert_in = 1'b1;
               go_in     = 1'b1;
               state_in  = ssmc_pkg::ST_HASH;
            end
         end
         ssmc_pkg::ST_HASH: begin
            if (hash_done) begin
               idx_in    = hash_slot;
               probes_in = '0;
               state_in  = ssmc_pkg::ST_READ;
            end
         end
         ssmc_pkg::ST_READ: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = ssmc_pkg::ST_CHECK;
         end
         ssmc_pkg::ST_CHECK: begin
            if (!insert_ff) begin
               if (hit) begin
                  match_in = ssmc_pkg::sat_add(match_ff, tbl_rd_data.count);
                  state_in = ssmc_pkg::ST_INSERT;
               end else if (!live || exhausted) begin
                  state_in = ssmc_pkg::ST_INSERT;
               end else begin
                  idx_in    = idx_next;
                  probes_in = probes_ff + IDX_W'(1);
                  state_in  = ssmc_pkg::ST_READ;
               end
            end else begin
               if (hit) begin
                  tbl_ctl.wr_en     = 1'b1;
                  tbl_wr_data.count = ssmc_pkg::sat_add(tbl_rd_data.count, 32'd1);
                  state_in          = ssmc_pkg::ST_DONE;
               end else if (!live) begin
                  // free slot on the probe path: claim it for this epoch
                  tbl_ctl.wr_en = 1'b1;
                  state_in      = ssmc_pkg::ST_DONE;
               end else if (exhausted) begin
                  ovf_in   = 1'b1;
                  state_in = ssmc_pkg::ST_DONE;
               end else begin
                  idx_in    = idx_next;
                  probes_in = probes_ff + IDX_W'(1);
                  state_in  = ssmc_pkg::ST_READ;
               end
            end
         end
         ssmc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ssmc_pkg::ST_IDLE;
               if (eos_ff) begin
                  sum_in      = '0;
                  match_in    = '0;
                  zero_cnt_in = 32'd1;
                  ovf_in      = 1'b0;
                  // a new epoch retires every entry; sweep only when tags run out
                  if (epoch_ff == ssmc_pkg::EPOCH_LAST) begin
                     epoch_in = ssmc_pkg::EPOCH_FIRST;
                     idx_in   = '0;
                     state_in = ssmc_pkg::ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + ssmc_pkg::EPOCH_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ssmc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* design/subarray_sum_match_counter.sv */
// Subarray sum match counter. Each stream word carries one signed 32-bit value
// (req_tdata) and an end-of-sequence mark (req_tlast). For every word accepted
// one result word comes back on rsp_: the saturating count of contiguous runs
// whose sum equals target_sum (rsp_tdata), the sticky table-full flag
// (rsp_tuser) and a copy of the end mark (rsp_tlast). target_sum is set through
// the csr_ port at byte address 0; it must be written by the user only while the
// block is idle, which the block itself does not enforce. One word is in work
// at a time: it is accepted, looked up in the table, inserted and its result
// loaded. Each lookup or insert runs a hash pass, then a table read and a check
// per probe; key zero needs no lookup, as it has its own counter. Each probe
// reads the single-port table memory, then checks the registered entry.
// A finished result waits in an output register while the next word is taken
// in; a stalled receiver holds only the word that finishes behind it.
// After reset, and after every 255th end of sequence, the table is swept slot by
// slot, during which req_tready stays low. The end mark clears the running sum,
// the counts and the flag as its result word is loaded.
module subarray_sum_match_counter #(
   parameter int TABLE_ENTRIES = ssmc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // end_of_sequence
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] match_total
   output logic [0:0]  rsp_tuser,   // [0] table_overflow
   output logic        rsp_tlast,   // final_result
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [31:0]             target_ff;
   logic                    target_sel;
   logic                    hash_start;
   logic [31:0]             hash_key;
   logic                    hash_done;
   logic [IDX_W-1:0]        hash_slot;
   ssmc_pkg::table_ctl_type tbl_ctl;
   logic [IDX_W-1:0]        tbl_addr;
   ssmc_pkg::entry_type     tbl_wr_data;
   ssmc_pkg::entry_type     tbl_rd_data;

   // register 0 sits at byte address 0; address 4 is unmapped
   assign target_sel = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = target_sel ? target_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && target_sel) begin
         target_ff <= csr_pwdata;
      end
   end

   ssmc_hash #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   ssmc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .addr    (tbl_addr),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   ssmc_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .target_sum  (target_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .hash_start  (hash_start),
      .hash_key    (hash_key),
      .hash_done   (hash_done),
      .hash_slot   (hash_slot),
      .tbl_ctl     (tbl_ctl),
      .tbl_addr    (tbl_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_data (tbl_rd_data)
   );

endmodule
